@@ design/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Shared sizes, request codes and channel payload types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pip_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int COORD_BITS   = 24;
   localparam int ADDR_W       = $clog2(MAX_VERTICES);
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int VTX_W        = 2 * COORD_BITS;
   localparam int DIFF_W       = COORD_BITS + 1;
   localparam int PROD_W       = 2 * DIFF_W;

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_TEST   = 2'd2;

   typedef struct packed {
      logic [1:0]                   mode;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic status;
   } rsp_type;

endpackage

@@ design/pip_ram.sv @@
// ----------------------------------------------------------------------------
// Point-in-polygon vertex RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pip_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ design/point_in_polygon_test.sv @@
// ----------------------------------------------------------------------------
// Point-in-polygon test: clear and append finish when accepted; results are registered.
// A query walks each edge (none if empty) and ends early on a boundary hit:
// one shared 25x25 multiplier is used twice per edge, then one compare.
// Synchronous reset empties the polygon; vertex RAM contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_polygon_test (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pip_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pip_pkg::rsp_type rsp_data
);

   import pip_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_PREV = 6'b000010,
      ST_EDGE = 6'b000100,
      ST_MUL2 = 6'b001000,
      ST_CMP  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [COORD_BITS-1:0] xj_ff, xj_in, yj_ff, yj_in;
   logic signed [COORD_BITS-1:0] xi_ff, xi_in, yi_ff, yi_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in, pa_ff, pa_in;
   logic straddle_ff, straddle_in, dpos_ff, dpos_in, parity_ff, parity_in;
   rsp_type hold_ff, hold_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [VTX_W-1:0]  rd_data;
   logic signed [COORD_BITS-1:0] rd_x, rd_y;
   logic signed [DIFF_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic [CNT_W-1:0] cnt_m1;
   logic             last_edge, out_free, fin;
   rsp_type          fin_res;

   pip_ram #(
      .WIDTH (VTX_W),
      .DEPTH (MAX_VERTICES)
   ) u_vtx_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({req_data.coord_y, req_data.coord_x}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_x      = rd_data[COORD_BITS-1:0];
   assign rd_y      = rd_data[VTX_W-1:COORD_BITS];
   assign cnt_m1    = count_ff - CNT_W'(1);
   assign last_edge = (cnt_m1 == CNT_W'(idx_ff));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign mul_p     = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (state_ff == ST_EDGE) begin
         mul_a = DIFF_W'(xj_ff) - DIFF_W'(rd_x);
         mul_b = DIFF_W'(py_ff) - DIFF_W'(rd_y);
      end else begin
         mul_a = DIFF_W'(px_ff) - DIFF_W'(xi_ff);
         mul_b = DIFF_W'(yj_ff) - DIFF_W'(yi_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      xj_in        = xj_ff;
      yj_in        = yj_ff;
      xi_in        = xi_ff;
      yi_in        = yi_ff;
      prod_in      = prod_ff;
      pa_in        = pa_ff;
      straddle_in  = straddle_ff;
      dpos_in      = dpos_ff;
      parity_in    = parity_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      rd_addr      = idx_ff;
      fin          = 1'b0;
      fin_res      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.mode)
                  MODE_CLEAR: begin
                     count_in = '0;
                     fin      = 1'b1;
                  end
                  MODE_APPEND: begin
                     fin = 1'b1;
                     if (count_ff < CNT_W'(MAX_VERTICES)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        fin_res.status = 1'b1;
                     end
                  end
                  MODE_TEST: begin
                     if (count_ff == '0) begin
                        fin = 1'b1;
                     end else begin
                        px_in     = req_data.coord_x;
                        py_in     = req_data.coord_y;
                        idx_in    = '0;
                        parity_in = 1'b0;
                        rd_addr   = cnt_m1[ADDR_W-1:0];
                        state_in  = ST_PREV;
                     end
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         ST_PREV: begin
            xj_in    = rd_x;
            yj_in    = rd_y;
            state_in = ST_EDGE;
         end
         ST_EDGE: begin
            xi_in       = rd_x;
            yi_in       = rd_y;
            prod_in     = mul_p;
            straddle_in = (rd_y > py_ff) != (yj_ff > py_ff);
            dpos_in     = (yj_ff > rd_y);
            state_in    = ST_MUL2;
            if ((rd_x == px_ff) && (rd_y == py_ff)) begin
               fin                = 1'b1;
               fin_res.inside_res = 1'b1;
            end
            if ((rd_y == yj_ff) && (rd_y == py_ff) &&
                (((rd_x <= px_ff) && (px_ff <= xj_ff)) ||
                 ((xj_ff <= px_ff) && (px_ff <= rd_x)))) begin
               fin                = 1'b1;
               fin_res.inside_res = 1'b1;
            end
         end
         ST_MUL2: begin
            pa_in    = prod_ff;
            prod_in  = mul_p;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (straddle_ff && (dpos_ff ? (pa_ff > prod_ff) : (pa_ff < prod_ff))) begin
               parity_in = !parity_ff;
            end
            xj_in = xi_ff;
            yj_in = yi_ff;
            if (last_edge) begin
               fin                = 1'b1;
               fin_res.inside_res = parity_in;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               rd_addr  = idx_in;
               state_in = ST_EDGE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hold_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (fin) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = fin_res;
            state_in     = ST_IDLE;
         end else begin
            hold_in  = fin_res;
            state_in = ST_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      xj_ff       <= xj_in;
      yj_ff       <= yj_in;
      xi_ff       <= xi_in;
      yi_ff       <= yi_in;
      prod_ff     <= prod_in;
      pa_ff       <= pa_in;
      straddle_ff <= straddle_in;
      dpos_ff     <= dpos_in;
      parity_ff   <= parity_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_data.mode == MODE_APPEND &&
       count_ff < CNT_W'(MAX_VERTICES))
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("append did not advance vertex count");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EDGE || state_ff == ST_MUL2 || state_ff == ST_CMP)
      |-> (CNT_W'(idx_ff) < count_ff))
      else $error("edge index beyond stored vertices");

   a_done_blocked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> rsp_valid_ff)
      else $error("pending request held with output register empty");
`endif

endmodule

@@ tb/point_in_polygon_checker.sv @@
// ----------------------------------------------------------------------------
// Point-in-polygon checker
// Watches both channels of the point-in-polygon block. It keeps its own copy
// of the polygon, works out the result of every accepted request by even-odd
// ray casting with an exact cross-multiplied comparison, and compares each
// accepted result with the oldest one still awaited.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_polygon_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  pip_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  pip_pkg::rsp_type rsp_data,
   output int               mismatches,
   output int               pending
);

   import pip_pkg::*;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   coord_type poly_x [MAX_VERTICES];
   coord_type poly_y [MAX_VERTICES];
   int      poly_size = 0;
   int      fault_count = 0;
   rsp_type awaited_rsp [$];

   assign mismatches = fault_count;
   assign pending    = awaited_rsp.size();

   function automatic logic point_lies_inside(input coord_type px, input coord_type py);
      int     prev;
      logic   parity;
      longint xi, yi, xj, yj, dy, lhs, rhs;
      parity = 1'b0;
      prev   = poly_size - 1;
      for (int k = 0; k < poly_size; k++) begin
         xi = poly_x[k];
         yi = poly_y[k];
         xj = poly_x[prev];
         yj = poly_y[prev];
         if (xi == px && yi == py)
            return 1'b1;
         if (yi == yj && yi == py && ((xi <= px && px <= xj) || (xj <= px && px <= xi)))
            return 1'b1;
         if ((yi > py) != (yj > py)) begin
            dy  = yj - yi;
            lhs = (xj - xi) * (py - yi);
            rhs = (px - xi) * dy;
            if ((dy > 0 && lhs > rhs) || (dy < 0 && lhs < rhs))
               parity = ~parity;
         end
         prev = k;
      end
      return parity;
   endfunction

   task automatic apply_request(input req_type r, output rsp_type o);
      o = '0;
      case (r.mode)
         MODE_CLEAR: begin
            poly_size = 0;
         end
         MODE_APPEND: begin
            if (poly_size < MAX_VERTICES) begin
               poly_x[poly_size] = r.coord_x;
               poly_y[poly_size] = r.coord_y;
               poly_size++;
            end else begin
               o.status = 1'b1;
            end
         end
         MODE_TEST: begin
            o.inside_res = point_lies_inside(r.coord_x, r.coord_y);
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         poly_size = 0;
         awaited_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: result with no request awaiting it: inside=%0b status=%0b",
                           $realtime, rsp_data.inside_res, rsp_data.status);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.inside_res !== want.inside_res || rsp_data.status !== want.status) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display({"%0t: wrong result: expected inside=%0b status=%0b, ",
                               "got inside=%0b status=%0b"},
                              $realtime, want.inside_res, want.status,
                              rsp_data.inside_res, rsp_data.status);
               end
            end
         end
         if (req_valid && !req_stall) begin
            apply_request(req_data, want);
            awaited_rsp = {awaited_rsp, want};
         end
      end
   end

endmodule

@@ tb/point_in_polygon_test_tb.sv @@
// ----------------------------------------------------------------------------
// Point-in-polygon testbench
// Drives clear, append, query and no-op requests into the block: a directed
// run over extreme coordinates, empty and degenerate polygons and boundary
// points, then random polygons probed with vertex, edge-line and nearby
// points, two store overflows and random noise. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_polygon_test_tb;

   import pip_pkg::*;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   localparam logic [1:0] MODE_IDLE   = 2'd3;
   localparam int         ITEM_TARGET = 1600;
   localparam int         STALL_LIMIT = 20000;
   localparam int         DRAIN_CYCLES = 16;
   localparam coord_type  C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam coord_type  C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    req_stall;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int        mismatches;
   int        pending;
   logic      calm = 1'b0;
   int        sent = 0;
   int        idle_cycles = 0;
   coord_type drawn_x [$];
   coord_type drawn_y [$];

   point_in_polygon_test DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   point_in_polygon_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 34);
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic req_type make_req(input logic [1:0] mode, input coord_type x,
                                        input coord_type y);
      req_type r;
      r.mode    = mode;
      r.coord_x = x;
      r.coord_y = y;
      return r;
   endfunction

   function automatic coord_type near_coord(input coord_type centre, input int span);
      int off;
      if (span == 0)
         return coord_type'($urandom);
      off = int'($urandom_range(0, 2 * span)) - span;
      return coord_type'(int'(centre) + off);
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic push_request(input req_type r);
      while (!calm && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      case (r.mode)
         MODE_CLEAR: begin
            drawn_x.delete();
            drawn_y.delete();
         end
         MODE_APPEND: begin
            if (drawn_x.size() < MAX_VERTICES) begin
               drawn_x = {drawn_x, r.coord_x};
               drawn_y = {drawn_y, r.coord_y};
            end
         end
         default: begin
         end
      endcase
      sent++;
      @(negedge clock);
   endtask

   initial begin
      int        fills_done;
      int        roll;
      int        span;
      int        count;
      int        idx;
      coord_type cx, cy, px, py;
      fills_done = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_request(make_req(MODE_TEST, 0, 0));
      push_request(make_req(MODE_IDLE, C_MAX, C_MIN));
      push_request(make_req(MODE_APPEND, C_MIN, C_MAX));
      push_request(make_req(MODE_TEST, C_MIN, C_MAX));
      push_request(make_req(MODE_TEST, C_MAX, C_MAX));
      push_request(make_req(MODE_APPEND, C_MAX, C_MIN));
      push_request(make_req(MODE_TEST, 0, 0));
      push_request(make_req(MODE_CLEAR, C_MAX, C_MAX));
      push_request(make_req(MODE_APPEND, C_MIN, C_MIN));
      push_request(make_req(MODE_APPEND, C_MAX, C_MIN));
      push_request(make_req(MODE_APPEND, C_MAX, C_MAX));
      push_request(make_req(MODE_APPEND, C_MIN, C_MAX));
      push_request(make_req(MODE_TEST, 0, 0));
      push_request(make_req(MODE_TEST, 5, C_MIN));
      push_request(make_req(MODE_TEST, C_MAX, C_MAX));
      push_request(make_req(MODE_TEST, C_MAX, 0));
      push_request(make_req(MODE_TEST, C_MIN, 0));
      push_request(make_req(MODE_TEST, 0, C_MAX));
      push_request(make_req(MODE_CLEAR, 0, 0));
      push_request(make_req(MODE_APPEND, C_MIN, C_MIN));
      push_request(make_req(MODE_APPEND, C_MAX, 0));
      push_request(make_req(MODE_APPEND, C_MIN, C_MAX));
      push_request(make_req(MODE_TEST, 0, 0));
      push_request(make_req(MODE_TEST, 0, 1));

      while (sent < ITEM_TARGET) begin
         calm = (sent >= 700 && sent < 1000);
         roll = $urandom_range(0, 99);
         cx   = coord_type'($urandom);
         cy   = coord_type'($urandom);
         if (fills_done < 2 && sent >= 400 + 600 * fills_done) begin
            // overflow the vertex store, then probe the full polygon
            fills_done++;
            push_request(make_req(MODE_CLEAR, cx, cy));
            for (int k = 0; k < MAX_VERTICES + 4; k++)
               push_request(make_req(MODE_APPEND, near_coord(cx, 5000), near_coord(cy, 5000)));
            repeat (4)
               push_request(make_req(MODE_TEST, near_coord(cx, 5000), near_coord(cy, 5000)));
         end else if (roll < 85) begin
            roll = $urandom_range(0, 9);
            span = roll < 3 ? 6 : roll < 7 ? 1000 : roll < 9 ? (1 << 22) : 0;
            if (drawn_x.size() > 200 || $urandom_range(0, 9) != 0)
               push_request(make_req(MODE_CLEAR, cx, cy));
            roll  = $urandom_range(0, 19);
            count = roll < 2 ? $urandom_range(1, 2) : roll < 18 ? $urandom_range(3, 10)
                                                     : $urandom_range(11, 48);
            repeat (count)
               push_request(make_req(MODE_APPEND, near_coord(cx, span), near_coord(cy, span)));
            repeat ($urandom_range(2, 8)) begin
               roll = $urandom_range(0, 9);
               px   = near_coord(cx, span);
               py   = near_coord(cy, span);
               if (drawn_x.size() > 0 && roll < 4) begin
                  idx = $urandom_range(0, drawn_x.size() - 1);
                  py  = drawn_y[idx];
                  if (roll < 2)
                     px = drawn_x[idx];
               end else if (roll == 9) begin
                  px = coord_type'($urandom);
                  py = coord_type'($urandom);
               end
               push_request(make_req(MODE_TEST, px, py));
            end
         end else begin
            repeat ($urandom_range(1, 4))
               push_request(make_req(2'($urandom_range(0, 3)), coord_type'($urandom),
                                     coord_type'($urandom)));
         end
      end

      req_valid <= 1'b0;
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
